// ===== rtl/core/pdr_pkg.sv =====
`default_nettype none
package pdr_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned PROD_W = 2 * WORD_W;
  // determinant and cofactor accumulation width: three fixed-point products
  localparam int unsigned DET_W = PROD_W - FRAC_BITS + 2;
  localparam int unsigned NUM_W = DET_W;
  localparam int unsigned DEN_W = DET_W;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_ITER = 1'b1;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [DET_W-1:0] det_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LDA,
    S_MUL,
    S_ACC,
    S_DMUL,
    S_DACC,
    S_DCHK,
    S_DIV,
    S_DWAIT,
    S_CMUL0,
    S_CMUL1,
    S_CDET,
    S_CCHK,
    S_CSQ0,
    S_CSQ1,
    S_CSQS,
    S_CSQW,
    S_CDIV,
    S_CDW,
    S_DONE
  } state_e;

  // operand pairs for the cofactors, two products per cofactor
  localparam logic [3:0] COF_A [18] = '{
    4'd4, 4'd5, 4'd5, 4'd3, 4'd3, 4'd4, 4'd2, 4'd1, 4'd0,
    4'd2, 4'd1, 4'd0, 4'd1, 4'd2, 4'd2, 4'd0, 4'd0, 4'd1
  };
  localparam logic [3:0] COF_B [18] = '{
    4'd8, 4'd7, 4'd6, 4'd8, 4'd7, 4'd6, 4'd7, 4'd8, 4'd8,
    4'd6, 4'd6, 4'd7, 4'd5, 4'd4, 4'd3, 4'd5, 4'd4, 4'd3
  };

  // clamp a wide signed value to one word
  function automatic word_t sat_word(input det_t v);
    word_t res;
    if (&v[DET_W-1:WORD_W-1] || ~|v[DET_W-1:WORD_W-1]) begin
      res = v[WORD_W-1:0];
    end else if (v[DET_W-1]) begin
      res = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(WORD_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pdr_mul.sv =====
`default_nettype none
module pdr_mul (
  input  wire logic                               clk_i,
  input  wire logic signed [pdr_pkg::WORD_W-1:0]  a_i,
  input  wire logic signed [pdr_pkg::WORD_W-1:0]  b_i,
  output logic signed [pdr_pkg::PROD_W-1:0]       p_o
);

  logic signed [pdr_pkg::PROD_W-1:0] p_q;
  logic signed [pdr_pkg::PROD_W-1:0] p_d;

  assign p_d = pdr_pkg::PROD_W'(a_i) * pdr_pkg::PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// ===== rtl/core/pdr_div.sv =====
`default_nettype none
module pdr_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [pdr_pkg::NUM_W-1:0]  num_i,
  input  wire logic signed [pdr_pkg::DEN_W-1:0]  den_i,
  output logic                                   done_o,
  output logic signed [pdr_pkg::WORD_W-1:0]      quo_o
);

  localparam int unsigned NW = pdr_pkg::NUM_W;
  localparam int unsigned DW = pdr_pkg::DEN_W;
  localparam int unsigned CW = pdr_pkg::CNT_W;
  localparam int unsigned WW = pdr_pkg::WORD_W;

  logic          run_q, run_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW:0]   rem_q, rem_d;
  logic [NW-1:0] nsh_q, nsh_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] dmag_q, dmag_d;
  logic          neg_q, neg_d;
  logic [DW:0]   rem_sh;
  logic [NW-1:0] mag_lim;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    nsh_d  = nsh_q;
    quo_d  = quo_q;
    dmag_d = dmag_q;
    neg_d  = neg_q;
    rem_sh = {rem_q[DW-1:0], nsh_q[NW-1]};
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = CW'(NW);
      rem_d  = '0;
      quo_d  = '0;
      nsh_d  = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
      dmag_d = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
      neg_d  = num_i[NW-1] ^ den_i[DW-1];
    end else if (run_q) begin
      // one quotient bit per cycle, restoring
      if (rem_sh >= {1'b0, dmag_q}) begin
        rem_d = rem_sh - {1'b0, dmag_q};
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      nsh_d = {nsh_q[NW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    nsh_q  <= nsh_d;
    quo_q  <= quo_d;
    dmag_q <= dmag_d;
    neg_q  <= neg_d;
  end

  assign mag_lim = NW'({1'b1, {(WW-1){1'b0}}});

  // truncate toward zero, then clamp to one word
  always_comb begin
    if (neg_q) begin
      quo_o = (quo_q > mag_lim) ? {1'b1, {(WW-1){1'b0}}} : WW'(-quo_q);
    end else begin
      quo_o = (quo_q >= mag_lim) ? {1'b0, {(WW-1){1'b1}}} : quo_q[WW-1:0];
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

// ===== rtl/core/pdr_sqrt.sv =====
`default_nettype none
module pdr_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] x_i,
  output logic             done_o,
  output logic [31:0]      root_o
);

  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] x_q, x_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [33:0] rem_sh;
  logic [33:0] trial;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    rem_sh = {rem_q[31:0], x_q[63:62]};
    trial  = {root_q, 2'b01};
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = 6'd32;
      x_d    = x_i;
      rem_d  = '0;
      root_d = '0;
    end else if (run_q) begin
      // two radicand bits per cycle, one root bit
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[30:0], 1'b0};
      end
      x_d   = {x_q[61:0], 2'b00};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 6'd1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

// ===== rtl/core/polar_decomposition_rotation_top.sv =====
`default_nettype none
// Rotation factor of a 3x3 matrix in signed Q16.16.
// Command channel: drive the nine in_m*_i words and pulse start while busy is
// low; the matrix is taken at that edge and busy stays high until the result
// is out. The result channel shows rot_m*_o and singular_o for one cycle,
// marked by done_o; the receiver must take it then, there is no back-pressure.
// Config: write cfg_data_i to register cfg_idx_i (0 = mode, 1 = step count)
// with cfg_we_i, only while idle.
// 3x3 mode: each Newton step is spent mostly on the nine quotients through
// the shared one-bit-per-cycle divider; with zero steps the matrix is passed
// to the result unchanged.
// A zero determinant ends the work early with singular set.
// 2x2 mode: the time is set by the square root and four divider passes.
// One matrix is in flight at a time; the next can start in the same cycle as
// done_o. Reset clears the sequencer and loads mode 0 with four steps.
module polar_decomposition_rotation_top #(
  parameter int MAX_ITERATIONS = 15
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [3:0]  cfg_data_i,
  input  wire logic signed [31:0] in_m00_i,
  input  wire logic signed [31:0] in_m01_i,
  input  wire logic signed [31:0] in_m02_i,
  input  wire logic signed [31:0] in_m10_i,
  input  wire logic signed [31:0] in_m11_i,
  input  wire logic signed [31:0] in_m12_i,
  input  wire logic signed [31:0] in_m20_i,
  input  wire logic signed [31:0] in_m21_i,
  input  wire logic signed [31:0] in_m22_i,
  output logic             done_o,
  output logic signed [31:0] rot_m00_o,
  output logic signed [31:0] rot_m01_o,
  output logic signed [31:0] rot_m02_o,
  output logic signed [31:0] rot_m10_o,
  output logic signed [31:0] rot_m11_o,
  output logic signed [31:0] rot_m12_o,
  output logic signed [31:0] rot_m20_o,
  output logic signed [31:0] rot_m21_o,
  output logic signed [31:0] rot_m22_o,
  output logic             singular_o
);

  localparam int unsigned WW = pdr_pkg::WORD_W;
  localparam int unsigned PW = pdr_pkg::PROD_W;
  localparam int unsigned DW = pdr_pkg::DET_W;
  localparam int unsigned FB = pdr_pkg::FRAC_BITS;

  pdr_pkg::state_e state_q, state_d;

  logic       mode_q;
  logic [3:0] itc_q;
  logic [3:0] n_eff;
  logic [4:0] k_q, k_d;
  logic [3:0] iter_q, iter_d;
  logic       sing_q, sing_d;

  pdr_pkg::word_t r_q [9];
  pdr_pkg::word_t r_d [9];
  pdr_pkg::word_t cof_q [9];
  pdr_pkg::word_t cof_d [9];
  pdr_pkg::word_t rot_q [9];
  pdr_pkg::word_t rot_d [9];
  logic signed [WW:0] t_q [4];
  logic signed [WW:0] t_d [4];
  pdr_pkg::det_t acc_q, acc_d;
  pdr_pkg::det_t det_q, det_d;
  pdr_pkg::word_t opa_q, opa_d;
  logic [63:0] sq_q, sq_d;
  logic [WW:0] den_q, den_d;
  logic        sing_out_q, sing_out_d;
  logic        done_q, done_d;

  logic [3:0]         rd_addr;
  pdr_pkg::word_t     r_rd;
  pdr_pkg::word_t     mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  pdr_pkg::det_t      fxp;
  pdr_pkg::det_t      sum;
  logic               div_start;
  logic signed [pdr_pkg::NUM_W-1:0] div_num;
  logic signed [pdr_pkg::DEN_W-1:0] div_den;
  logic               div_done;
  pdr_pkg::word_t     div_q;
  logic               sqrt_start;
  logic [63:0]        sqrt_x;
  logic               sqrt_done;
  logic [31:0]        sqrt_root;
  logic signed [WW:0] avg;
  pdr_pkg::word_t     h0, h1;
  logic               pos;

  pdr_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  pdr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  pdr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .x_i     (sqrt_x),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      itc_q  <= 4'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pdr_pkg::REG_MODE: mode_q <= cfg_data_i[0];
        pdr_pkg::REG_ITER: itc_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign n_eff = (int'(itc_q) > MAX_ITERATIONS) ? 4'(MAX_ITERATIONS) : itc_q;

  assign r_rd = r_q[rd_addr];
  assign fxp  = pdr_pkg::det_t'($signed(mul_p[PW-1:FB]));
  assign h0   = t_q[0][WW:1];
  assign h1   = t_q[2][WW:1];
  assign pos  = !det_q[DW-1];

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    iter_d     = iter_q;
    sing_d     = sing_q;
    r_d        = r_q;
    cof_d      = cof_q;
    rot_d      = rot_q;
    t_d        = t_q;
    acc_d      = acc_q;
    det_d      = det_q;
    opa_d      = opa_q;
    sq_d       = sq_q;
    den_d      = den_q;
    sing_out_d = sing_out_q;
    done_d     = 1'b0;
    rd_addr    = k_q[3:0];
    mul_a      = opa_q;
    mul_b      = r_rd;
    sum        = fxp;
    div_start  = 1'b0;
    div_num    = pdr_pkg::NUM_W'(cof_q[k_q[3:0]]) <<< FB;
    div_den    = det_q;
    sqrt_start = 1'b0;
    sqrt_x     = sq_q + 64'(mul_p);
    avg        = (WW+1)'(r_rd) + (WW+1)'(div_q);

    case (state_q)
      pdr_pkg::S_IDLE: begin
        if (start) begin
          r_d[0] = in_m00_i; r_d[1] = in_m01_i; r_d[2] = in_m02_i;
          r_d[3] = in_m10_i; r_d[4] = in_m11_i; r_d[5] = in_m12_i;
          r_d[6] = in_m20_i; r_d[7] = in_m21_i; r_d[8] = in_m22_i;
          sing_d = 1'b0;
          iter_d = '0;
          k_d    = '0;
          if (mode_q) begin
            state_d = pdr_pkg::S_CMUL0;
          end else if (n_eff == 4'd0) begin
            state_d = pdr_pkg::S_DONE;
          end else begin
            state_d = pdr_pkg::S_LDA;
          end
        end
      end
      pdr_pkg::S_LDA: begin
        rd_addr = pdr_pkg::COF_A[k_q];
        opa_d   = r_rd;
        state_d = pdr_pkg::S_MUL;
      end
      pdr_pkg::S_MUL: begin
        rd_addr = pdr_pkg::COF_B[k_q];
        state_d = pdr_pkg::S_ACC;
      end
      pdr_pkg::S_ACC: begin
        // even product opens a cofactor, odd product closes it
        if (!k_q[0]) begin
          acc_d = fxp;
        end else begin
          cof_d[k_q[4:1]] = pdr_pkg::sat_word(acc_q - fxp);
        end
        if (k_q == 5'd17) begin
          k_d     = '0;
          state_d = pdr_pkg::S_DMUL;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = pdr_pkg::S_LDA;
        end
      end
      pdr_pkg::S_DMUL: begin
        mul_a   = r_rd;
        mul_b   = cof_q[k_q[3:0]];
        state_d = pdr_pkg::S_DACC;
      end
      pdr_pkg::S_DACC: begin
        sum = (k_q == 5'd0) ? fxp : acc_q + fxp;
        if (k_q == 5'd2) begin
          det_d   = sum;
          state_d = pdr_pkg::S_DCHK;
        end else begin
          acc_d   = sum;
          k_d     = k_q + 1'b1;
          state_d = pdr_pkg::S_DMUL;
        end
      end
      pdr_pkg::S_DCHK: begin
        k_d = '0;
        if (det_q == '0) begin
          sing_d  = 1'b1;
          state_d = pdr_pkg::S_DONE;
        end else begin
          state_d = pdr_pkg::S_DIV;
        end
      end
      pdr_pkg::S_DIV: begin
        div_start = 1'b1;
        state_d   = pdr_pkg::S_DWAIT;
      end
      pdr_pkg::S_DWAIT: begin
        if (div_done) begin
          r_d[k_q[3:0]] = avg[WW:1];
          if (k_q == 5'd8) begin
            k_d    = '0;
            iter_d = iter_q + 1'b1;
            if ({1'b0, iter_q} + 5'd1 == {1'b0, n_eff}) begin
              state_d = pdr_pkg::S_DONE;
            end else begin
              state_d = pdr_pkg::S_LDA;
            end
          end else begin
            k_d     = k_q + 1'b1;
            state_d = pdr_pkg::S_DIV;
          end
        end
      end
      pdr_pkg::S_CMUL0: begin
        mul_a   = r_q[0];
        mul_b   = r_q[4];
        state_d = pdr_pkg::S_CMUL1;
      end
      pdr_pkg::S_CMUL1: begin
        mul_a   = r_q[1];
        mul_b   = r_q[3];
        acc_d   = fxp;
        state_d = pdr_pkg::S_CDET;
      end
      pdr_pkg::S_CDET: begin
        det_d   = acc_q - fxp;
        state_d = pdr_pkg::S_CCHK;
      end
      pdr_pkg::S_CCHK: begin
        // add or subtract the swapped block by the sign of the determinant
        if (pos) begin
          t_d[0] = (WW+1)'(r_q[0]) + (WW+1)'(r_q[4]);
          t_d[1] = (WW+1)'(r_q[1]) - (WW+1)'(r_q[3]);
          t_d[2] = (WW+1)'(r_q[3]) - (WW+1)'(r_q[1]);
          t_d[3] = (WW+1)'(r_q[4]) + (WW+1)'(r_q[0]);
        end else begin
          t_d[0] = (WW+1)'(r_q[0]) - (WW+1)'(r_q[4]);
          t_d[1] = (WW+1)'(r_q[1]) + (WW+1)'(r_q[3]);
          t_d[2] = (WW+1)'(r_q[3]) + (WW+1)'(r_q[1]);
          t_d[3] = (WW+1)'(r_q[4]) - (WW+1)'(r_q[0]);
        end
        r_d[2] = '0; r_d[5] = '0; r_d[6] = '0; r_d[7] = '0; r_d[8] = '0;
        if (det_q == '0) begin
          sing_d  = 1'b1;
          state_d = pdr_pkg::S_DONE;
        end else begin
          state_d = pdr_pkg::S_CSQ0;
        end
      end
      pdr_pkg::S_CSQ0: begin
        mul_a   = h0;
        mul_b   = h0;
        state_d = pdr_pkg::S_CSQ1;
      end
      pdr_pkg::S_CSQ1: begin
        mul_a   = h1;
        mul_b   = h1;
        sq_d    = 64'(mul_p);
        state_d = pdr_pkg::S_CSQS;
      end
      pdr_pkg::S_CSQS: begin
        sqrt_start = 1'b1;
        state_d    = pdr_pkg::S_CSQW;
      end
      pdr_pkg::S_CSQW: begin
        if (sqrt_done) begin
          den_d = {sqrt_root, 1'b0};
          k_d   = '0;
          if (sqrt_root == '0) begin
            sing_d  = 1'b1;
            state_d = pdr_pkg::S_DONE;
          end else begin
            state_d = pdr_pkg::S_CDIV;
          end
        end
      end
      pdr_pkg::S_CDIV: begin
        div_num   = pdr_pkg::NUM_W'(t_q[k_q[1:0]]) <<< FB;
        div_den   = pdr_pkg::DEN_W'(den_q);
        div_start = 1'b1;
        state_d   = pdr_pkg::S_CDW;
      end
      pdr_pkg::S_CDW: begin
        if (div_done) begin
          // quotients land on the upper-left block: 0, 1, 3, 4
          r_d[{2'b00, k_q[1], k_q[1]} + {3'b000, k_q[0]}] = div_q;
          if (k_q == 5'd3) begin
            state_d = pdr_pkg::S_DONE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = pdr_pkg::S_CDIV;
          end
        end
      end
      pdr_pkg::S_DONE: begin
        for (int i = 0; i < 9; i++) begin
          rot_d[i] = sing_q ? '0 : r_q[i];
        end
        sing_out_d = sing_q;
        done_d     = 1'b1;
        state_d    = pdr_pkg::S_IDLE;
      end
      default: begin
        state_d = pdr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pdr_pkg::S_IDLE;
      k_q     <= '0;
      iter_q  <= '0;
      sing_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      iter_q  <= iter_d;
      sing_q  <= sing_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q        <= r_d;
    cof_q      <= cof_d;
    rot_q      <= rot_d;
    t_q        <= t_d;
    acc_q      <= acc_d;
    det_q      <= det_d;
    opa_q      <= opa_d;
    sq_q       <= sq_d;
    den_q      <= den_d;
    sing_out_q <= sing_out_d;
  end

  assign busy       = (state_q != pdr_pkg::S_IDLE);
  assign done_o     = done_q;
  assign singular_o = sing_out_q;
  assign rot_m00_o  = rot_q[0];
  assign rot_m01_o  = rot_q[1];
  assign rot_m02_o  = rot_q[2];
  assign rot_m10_o  = rot_q[3];
  assign rot_m11_o  = rot_q[4];
  assign rot_m12_o  = rot_q[5];
  assign rot_m20_o  = rot_q[6];
  assign rot_m21_o  = rot_q[7];
  assign rot_m22_o  = rot_q[8];

`ifndef SYNTH
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done_o held for more than one cycle");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted transaction did not raise busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result without a transaction in flight");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && singular_o) |-> (rot_m00_o == '0 && rot_m11_o == '0 && rot_m22_o == '0))
    else $error("singular result carries nonzero rotation");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_polar_decomposition_rotation_top.sv =====
`default_nettype none
module tb_polar_decomposition_rotation_top;

  typedef logic [8:0][31:0] matrix_t;
  typedef struct packed {
    matrix_t rot;
    logic    sing;
  } rotation_t;

  localparam int WATCHDOG_LIMIT = 60000;
  localparam int ONE = 1 << 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = pdr_pkg::REG_MODE;
  logic [3:0] cfg_data_i = '0;
  matrix_t mat_q = '0;
  logic done_o;
  logic signed [31:0] rot_o [9];
  logic singular_o;

  matrix_t   pending_q[$];
  rotation_t rotation_q[$];
  logic       mode_2x2 = 1'b0;
  logic [3:0] step_count = 4'd4;
  int         idle_pct = 33;
  int         errors = 0;
  int         quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  polar_decomposition_rotation_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .in_m00_i(mat_q[0]), .in_m01_i(mat_q[1]), .in_m02_i(mat_q[2]),
    .in_m10_i(mat_q[3]), .in_m11_i(mat_q[4]), .in_m12_i(mat_q[5]),
    .in_m20_i(mat_q[6]), .in_m21_i(mat_q[7]), .in_m22_i(mat_q[8]),
    .done_o(done_o),
    .rot_m00_o(rot_o[0]), .rot_m01_o(rot_o[1]), .rot_m02_o(rot_o[2]),
    .rot_m10_o(rot_o[3]), .rot_m11_o(rot_o[4]), .rot_m12_o(rot_o[5]),
    .rot_m20_o(rot_o[6]), .rot_m21_o(rot_o[7]), .rot_m22_o(rot_o[8]),
    .singular_o(singular_o)
  );

  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint clamp_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic bit newton_average(ref longint r[9]);
    longint cof[9];
    longint det;
    cof[0] = clamp_word(fx_mul(r[4], r[8]) - fx_mul(r[5], r[7]));
    cof[1] = clamp_word(fx_mul(r[5], r[6]) - fx_mul(r[3], r[8]));
    cof[2] = clamp_word(fx_mul(r[3], r[7]) - fx_mul(r[4], r[6]));
    cof[3] = clamp_word(fx_mul(r[2], r[7]) - fx_mul(r[1], r[8]));
    cof[4] = clamp_word(fx_mul(r[0], r[8]) - fx_mul(r[2], r[6]));
    cof[5] = clamp_word(fx_mul(r[1], r[6]) - fx_mul(r[0], r[7]));
    cof[6] = clamp_word(fx_mul(r[1], r[5]) - fx_mul(r[2], r[4]));
    cof[7] = clamp_word(fx_mul(r[2], r[3]) - fx_mul(r[0], r[5]));
    cof[8] = clamp_word(fx_mul(r[0], r[4]) - fx_mul(r[1], r[3]));
    det = fx_mul(r[0], cof[0]) + fx_mul(r[1], cof[1]) + fx_mul(r[2], cof[2]);
    if (det == 0) return 1'b0;
    for (int i = 0; i < 9; i++) r[i] = (r[i] + clamp_word((cof[i] * ONE) / det)) >>> 1;
    return 1'b1;
  endfunction

  function automatic bit closed_form_2x2(ref longint r[9]);
    longint det, s, h0, h1, den;
    longint t[4];
    longint unsigned nh;
    det = fx_mul(r[0], r[4]) - fx_mul(r[1], r[3]);
    if (det == 0) return 1'b0;
    s = (det > 0) ? 1 : -1;
    t[0] = r[0] + s * r[4];
    t[1] = r[1] - s * r[3];
    t[2] = r[3] - s * r[1];
    t[3] = r[4] + s * r[0];
    h0 = t[0] >>> 1;
    h1 = t[2] >>> 1;
    nh = sqrt_floor(longint'(h0 * h0) + longint'(h1 * h1));
    if (nh == 0) return 1'b0;
    den = 2 * longint'(nh);
    for (int i = 0; i < 9; i++) r[i] = 0;
    r[0] = clamp_word((t[0] * ONE) / den);
    r[1] = clamp_word((t[1] * ONE) / den);
    r[3] = clamp_word((t[2] * ONE) / den);
    r[4] = clamp_word((t[3] * ONE) / den);
    return 1'b1;
  endfunction

  function automatic rotation_t predict_rotation(matrix_t m);
    longint r[9];
    bit ok;
    int n;
    rotation_t res;
    ok = 1'b1;
    for (int i = 0; i < 9; i++) r[i] = longint'($signed(m[i]));
    if (mode_2x2) begin
      ok = closed_form_2x2(r);
    end else begin
      n = (step_count > 15) ? 15 : step_count;
      for (int i = 0; i < n && ok; i++) ok = newton_average(r);
    end
    for (int i = 0; i < 9; i++) res.rot[i] = ok ? r[i][31:0] : 32'd0;
    res.sing = !ok;
    return res;
  endfunction

  // driver: present the next matrix, hold it until accepted
  always @(posedge clk_i) begin
    logic fire;
    fire = start && !busy;
    if (fire) rotation_q.push_back(predict_rotation(mat_q));
    if (!start || fire) begin
      if (pending_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        mat_q <= pending_q.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: each done_o transaction is checked against the oldest prediction
  always @(posedge clk_i) begin
    rotation_t exp_r;
    if (done_o) begin
      if (rotation_q.size() == 0) begin
        $error("result with no matrix outstanding");
        errors++;
      end else begin
        exp_r = rotation_q.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (rot_o[i] !== exp_r.rot[i]) begin
            $error("rot_m%0d%0d expected %h actual %h", i / 3, i % 3, exp_r.rot[i], rot_o[i]);
            errors++;
          end
        end
        if (singular_o !== exp_r.sing) begin
          $error("singular expected %b actual %b", exp_r.sing, singular_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] rand_word(int idx);
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 32'h60000) - 32'h30000;
      2: return ((idx % 4 == 0) ? 32'h10000 : 32'h0) + $urandom_range(0, 32'h4000) - 32'h2000;
      3: return $urandom_range(0, 15) - 8;
      default: begin
        case ($urandom_range(0, 6))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h10000;
          3: return 32'hffff0000;
          4: return 32'hffffffff;
          5: return 32'h1;
          default: return 32'h0;
        endcase
      end
    endcase
  endfunction

  task automatic queue_directed();
    matrix_t m;
    m = '0; m[0] = 32'h10000; m[4] = 32'h10000; m[8] = 32'h10000;
    pending_q.push_back(m);
    m[0] = 32'h20000; m[4] = 32'hfffe0000; m[8] = 32'h8000;
    pending_q.push_back(m);
    m = '0; m[1] = 32'hffff0000; m[3] = 32'h10000; m[8] = 32'h10000;
    pending_q.push_back(m);
    pending_q.push_back('0);
    pending_q.push_back({9{32'h7fffffff}});
    pending_q.push_back({9{32'h80000000}});
    for (int i = 0; i < 9; i++) m[i] = (i % 2) ? 32'h80000000 : 32'h7fffffff;
    pending_q.push_back(m);
    for (int i = 0; i < 9; i++) m[i] = 32'h10000 * (i + 1);
    pending_q.push_back(m);
    m = '0; m[1] = 32'h1; m[3] = 32'hffffffff;
    pending_q.push_back(m);
  endtask

  task automatic queue_random(int count);
    matrix_t m;
    for (int k = 0; k < count; k++) begin
      for (int i = 0; i < 9; i++) m[i] = rand_word(i);
      pending_q.push_back(m);
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || rotation_q.size() > 0 || start || busy) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [3:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    if (idx == pdr_pkg::REG_MODE) mode_2x2 = data[0];
    else step_count = data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(logic mode, logic [3:0] steps, int pct, int count);
    wait_drained();
    write_reg(pdr_pkg::REG_MODE, {3'($urandom), mode});
    write_reg(pdr_pkg::REG_ITER, steps);
    idle_pct = pct;
    queue_directed();
    queue_random(count);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset settings first: 3x3, four steps
    queue_directed();
    queue_random(45);
    run_phase(1'b1, 4'd7, 33, 130);
    run_phase(1'b0, 4'd0, 33, 60);
    run_phase(1'b0, 4'd1, 62, 70);
    run_phase(1'b0, 4'd15, 62, 4);
    run_phase(1'b1, 4'd15, 62, 60);
    run_phase(1'b0, 4'd2, 0, 40);
    run_phase(1'b1, 4'd0, 0, 40);
    run_phase(1'b0, 4'd3, 0, 20);
    wait_drained();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/pdr_pkg.sv
rtl/core/pdr_mul.sv
rtl/core/pdr_div.sv
rtl/core/pdr_sqrt.sv
rtl/core/polar_decomposition_rotation_top.sv
verif/tb_polar_decomposition_rotation_top.sv
